// ===== design/jfp_pkg.sv =====
// Shared constants for the joystick frame parser.
`timescale 1ns / 1ps

package jfp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ID_W        = 64;
    localparam int unsigned POS_W       = 16;
    localparam int unsigned VIDX_W      = 4;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned MATCH_W     = 2;
    localparam int unsigned APB_ADDR_W  = 6;
    localparam int unsigned APB_DATA_W  = 64;
    localparam int unsigned REG_IDX_W   = 3;

    localparam logic [POS_W-1:0]  POS_RESET  = 16'd512;
    localparam logic [POS_W-1:0]  ASCII_ZERO = 16'd48;
    localparam logic [VIDX_W-1:0] VIDX_MAX   = 4'd15;
    localparam logic [CNT_W-1:0]  CNT_MAX    = 4'd9;

    typedef logic [MATCH_W-1:0] t_match;
    localparam t_match MATCH_NONE  = 2'd0;
    localparam t_match MATCH_LEFT  = 2'd1;
    localparam t_match MATCH_RIGHT = 2'd2;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_ID     = 2'd0;
    localparam t_mode MODE_VALUE  = 2'd1;
    localparam t_mode MODE_CLOSED = 2'd2;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_START    = 3'd0;
    localparam t_reg_idx REG_TEXT     = 3'd1;
    localparam t_reg_idx REG_SEP      = 3'd2;
    localparam t_reg_idx REG_END      = 3'd3;
    localparam t_reg_idx REG_LEFT_ID  = 3'd4;
    localparam t_reg_idx REG_RIGHT_ID = 3'd5;

endpackage

// ===== design/jfp_if.sv =====
// Stream interfaces for received bytes and parsed frame results.
`timescale 1ns / 1ps

interface jfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface jfp_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  matched_stick;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [3:0]  value_count;
    logic        id_too_long;

    modport source (output valid, output matched_stick, output left_x, output left_y,
                    output right_x, output right_y, output value_count,
                    output id_too_long, input ready);
    modport sink   (input valid, input matched_stick, input left_x, input left_y,
                    input right_x, input right_y, input value_count,
                    input id_too_long, output ready);
endinterface

// ===== design/joystick_frame_parser_top.sv =====
// Joystick frame parser: byte-stream delimiter decoder with stick position registers.
`timescale 1ns / 1ps

// The parser takes one received byte per clock cycle, save for the stall named
// below. A byte is captured in an input register, decoded against the four
// delimiter codes in the following cycle, and an end byte loads the result
// register, from which the result is offered. Throughput is one byte per cycle,
// set by the single decode step between the input and result registers; the
// only stall is an end byte that finds the result register still holding an
// untaken result, in which case it waits in the input register. Delimiter
// codes and stick IDs are written through the APB port at byte address 8*i
// and should only be changed while no frame is in flight.
module joystick_frame_parser_top #(
    parameter int unsigned MAX_VALUES = 8,
    parameter int unsigned ID_BYTES   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    jfp_rx_if.sink                        i_rx,
    jfp_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [jfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [jfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready
);
    import jfp_pkg::*;

    localparam int unsigned IDX_W = $clog2(ID_BYTES + 1);

    // Configuration registers.
    logic [BYTE_W-1:0] r_start_code, r_text_code, r_sep_code, r_end_code;
    logic [ID_W-1:0]   r_left_id, r_right_id;

    // Parser state.
    t_mode              r_mode, n_mode;
    logic [ID_W-1:0]    r_id_buf, n_id_buf;
    logic [IDX_W-1:0]   r_id_idx, n_id_idx;
    logic               r_id_ovf, n_id_ovf;
    logic [VIDX_W-1:0]  r_vidx, n_vidx;
    logic [POS_W-1:0]   r_acc0, n_acc0, r_acc1, n_acc1;
    logic               r_drop, n_drop;
    logic [POS_W-1:0]   r_lx, n_lx, r_ly, n_ly, r_rx, n_rx, r_ry, n_ry;

    // Input register and result register.
    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_out_valid;
    t_match             r_out_match, n_match;
    logic [POS_W-1:0]   r_out_lx, r_out_ly, r_out_rx, r_out_ry;
    logic [CNT_W-1:0]   r_out_cnt, n_cnt;
    logic               r_out_ovf;

    logic w_is_start, w_is_text, w_is_sep, w_is_end;
    logic w_out_free, w_advance, w_cfg_wr;
    logic [POS_W-1:0] w_acc_sel, w_acc_new;
    t_reg_idx w_reg_idx;

    assign w_is_start = (r_in_byte == r_start_code);
    assign w_is_text  = (r_in_byte == r_text_code);
    assign w_is_sep   = (r_in_byte == r_sep_code);
    assign w_is_end   = (r_in_byte == r_end_code);

    assign w_out_free = !r_out_valid || o_res.ready;
    // An end byte may only leave the input register when the result register can take it.
    assign w_advance  = r_in_valid && (!w_is_end || w_is_start || w_is_text || w_is_sep
                                       || w_out_free);
    assign i_rx.ready = !r_in_valid || w_advance;

    // acc * 10 + byte - '0', wrapping at 16 bits.
    assign w_acc_sel = r_vidx[0] ? r_acc1 : r_acc0;
    assign w_acc_new = (w_acc_sel << 3) + (w_acc_sel << 1)
                       + {{(POS_W-BYTE_W){1'b0}}, r_in_byte} - ASCII_ZERO;

    always_comb begin
        n_mode   = r_mode;
        n_id_buf = r_id_buf;
        n_id_idx = r_id_idx;
        n_id_ovf = r_id_ovf;
        n_vidx   = r_vidx;
        n_acc0   = r_acc0;
        n_acc1   = r_acc1;
        n_drop   = r_drop;
        n_lx     = r_lx;
        n_ly     = r_ly;
        n_rx     = r_rx;
        n_ry     = r_ry;
        n_match  = MATCH_NONE;
        n_cnt    = (r_vidx >= 4'd8) ? CNT_MAX : r_vidx + 4'd1;

        priority if (w_is_start) begin
            n_mode   = MODE_ID;
            n_id_buf = '0;
            n_id_idx = '0;
            n_id_ovf = 1'b0;
            n_acc0   = '0;
            n_acc1   = '0;
        end else if (w_is_text) begin
            n_mode = MODE_VALUE;
            n_vidx = '0;
        end else if (w_is_sep) begin
            n_mode = MODE_VALUE;
            if (r_vidx != VIDX_MAX) begin
                n_vidx = r_vidx + 4'd1;
            end
            if (n_vidx >= VIDX_W'(MAX_VALUES)) begin
                n_drop = 1'b1;
            end
        end else if (w_is_end) begin
            if (!r_id_ovf) begin
                if (r_id_buf == r_left_id) begin
                    n_match = MATCH_LEFT;
                    n_lx    = r_acc0;
                    n_ly    = r_acc1;
                end else if (r_id_buf == r_right_id) begin
                    n_match = MATCH_RIGHT;
                    n_rx    = r_acc0;
                    n_ry    = r_acc1;
                end
            end
            n_id_buf = '0;
            n_id_idx = '0;
            n_id_ovf = 1'b0;
            n_acc0   = '0;
            n_acc1   = '0;
            n_drop   = 1'b0;
            n_mode   = MODE_CLOSED;
        end else if (!r_drop) begin
            if (r_mode == MODE_ID) begin
                if (r_id_idx < IDX_W'(ID_BYTES)) begin
                    for (int k = 0; k < ID_BYTES; k++) begin
                        if (r_id_idx == IDX_W'(k)) begin
                            n_id_buf[8*k +: 8] = r_in_byte;
                        end
                    end
                    n_id_idx = r_id_idx + 1'b1;
                end else begin
                    n_id_ovf = 1'b1;
                end
            end else if (r_mode == MODE_VALUE && r_vidx < 4'd2) begin
                if (r_vidx[0]) begin
                    n_acc1 = w_acc_new;
                end else begin
                    n_acc0 = w_acc_new;
                end
            end
        end else begin
            // Data bytes are ignored while the value list is being dropped.
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Parser state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ID;
            r_id_buf <= '0;
            r_id_idx <= '0;
            r_id_ovf <= 1'b0;
            r_vidx   <= '0;
            r_acc0   <= '0;
            r_acc1   <= '0;
            r_drop   <= 1'b0;
            r_lx     <= POS_RESET;
            r_ly     <= POS_RESET;
            r_rx     <= POS_RESET;
            r_ry     <= POS_RESET;
        end else if (w_advance) begin
            r_mode   <= n_mode;
            r_id_buf <= n_id_buf;
            r_id_idx <= n_id_idx;
            r_id_ovf <= n_id_ovf;
            r_vidx   <= n_vidx;
            r_acc0   <= n_acc0;
            r_acc1   <= n_acc1;
            r_drop   <= n_drop;
            r_lx     <= n_lx;
            r_ly     <= n_ly;
            r_rx     <= n_rx;
            r_ry     <= n_ry;
        end
    end

    // Result register.
    logic w_load_out;
    assign w_load_out = w_advance && w_is_end && !w_is_start && !w_is_text && !w_is_sep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_match <= n_match;
            r_out_lx    <= n_lx;
            r_out_ly    <= n_ly;
            r_out_rx    <= n_rx;
            r_out_ry    <= n_ry;
            r_out_cnt   <= n_cnt;
            r_out_ovf   <= r_id_ovf;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.matched_stick = r_out_match;
    assign o_res.left_x        = r_out_lx;
    assign o_res.left_y        = r_out_ly;
    assign o_res.right_x       = r_out_rx;
    assign o_res.right_y       = r_out_ry;
    assign o_res.value_count   = r_out_cnt;
    assign o_res.id_too_long   = r_out_ovf;

    // APB configuration port.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code <= 8'd1;
            r_text_code  <= 8'd2;
            r_sep_code   <= 8'd3;
            r_end_code   <= 8'd4;
            r_left_id    <= '0;
            r_right_id   <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_START:    r_start_code <= pwdata[BYTE_W-1:0];
                REG_TEXT:     r_text_code  <= pwdata[BYTE_W-1:0];
                REG_SEP:      r_sep_code   <= pwdata[BYTE_W-1:0];
                REG_END:      r_end_code   <= pwdata[BYTE_W-1:0];
                REG_LEFT_ID:  r_left_id    <= pwdata;
                REG_RIGHT_ID: r_right_id   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_START:    prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, r_start_code};
            REG_TEXT:     prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, r_text_code};
            REG_SEP:      prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, r_sep_code};
            REG_END:      prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, r_end_code};
            REG_LEFT_ID:  prdata = r_left_id;
            REG_RIGHT_ID: prdata = r_right_id;
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== design/jfp_checker.sv =====
// Port-level checker for the joystick frame parser, bound to the top level.
`timescale 1ns / 1ps

module jfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [1:0]  i_matched_stick,
    input logic [15:0] i_left_x,
    input logic [3:0]  i_value_count,
    input logic        i_id_too_long
);
    import jfp_pkg::*;

    // A result that is not taken stays offered.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped before transaction completed");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_left_x) && $stable(i_matched_stick))
        else $error("stalled result payload changed");

    // An overlong identifier never selects a stick.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_id_too_long |-> i_matched_stick == MATCH_NONE)
        else $error("overlong identifier matched a stick");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_matched_stick == MATCH_NONE || i_matched_stick == MATCH_LEFT
                        || i_matched_stick == MATCH_RIGHT)
        else $error("invalid stick match code");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_value_count != 4'd0 && i_value_count <= CNT_MAX)
        else $error("value count out of range");

endmodule

bind joystick_frame_parser_top jfp_checker u_jfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_matched_stick(o_res.matched_stick),
    .i_left_x       (o_res.left_x),
    .i_value_count  (o_res.value_count),
    .i_id_too_long  (o_res.id_too_long)
);
